/* rtl/st_pkg.sv */
// ----------------------------------------------------------------------------
// st_pkg
// Shared codes, constants and character classes for the source tokenizer.
// ----------------------------------------------------------------------------
package st_pkg;

    // Default widths of the position, line and length fields.
    localparam int POSITION_BITS_DEF = 24;
    localparam int LINE_BITS_DEF     = 24;
    localparam int LENGTH_BITS_DEF   = 16;

    // Depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_BITS = 31;
    localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

    // Token kinds.
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_TILDE   = 6'd11;
    localparam logic [5:0] K_MOD     = 6'd12;
    localparam logic [5:0] K_BANG    = 6'd13;
    localparam logic [5:0] K_BANG_EQ = 6'd14;
    localparam logic [5:0] K_EQ      = 6'd15;
    localparam logic [5:0] K_EQ_EQ   = 6'd16;
    localparam logic [5:0] K_GT      = 6'd17;
    localparam logic [5:0] K_GE      = 6'd18;
    localparam logic [5:0] K_LT      = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_SHL     = 6'd21;
    localparam logic [5:0] K_SHR     = 6'd22;
    localparam logic [5:0] K_DEC     = 6'd23;
    localparam logic [5:0] K_IDENT   = 6'd24;
    localparam logic [5:0] K_STRING  = 6'd25;
    localparam logic [5:0] K_NUMBER  = 6'd26;
    localparam logic [5:0] K_AND     = 6'd27;
    localparam logic [5:0] K_INT     = 6'd28;
    localparam logic [5:0] K_OR      = 6'd29;
    localparam logic [5:0] K_RETURN  = 6'd30;
    localparam logic [5:0] K_VOID    = 6'd31;
    localparam logic [5:0] K_XOR     = 6'd32;
    localparam logic [5:0] K_ERROR   = 6'd33;
    localparam logic [5:0] K_EOF     = 6'd34;

    // Error codes.
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_CHAR   = 2'd1;
    localparam logic [1:0] E_DIGIT  = 2'd2;
    localparam logic [1:0] E_STRING = 2'd3;

    // Scanner modes.
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_IDENT   = 4'd3;
    localparam logic [3:0] M_NUMBER  = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_MINUS   = 4'd6;
    localparam logic [3:0] M_BANG    = 4'd7;
    localparam logic [3:0] M_EQUAL   = 4'd8;
    localparam logic [3:0] M_LESS    = 4'd9;
    localparam logic [3:0] M_GREATER = 4'd10;
    localparam logic [3:0] M_ERROR   = 4'd11;

    // Keywords, packed as the last identifier bytes.
    localparam logic [47:0] KW_INT    = 48'h0000_0069_6E74;
    localparam logic [47:0] KW_VOID   = 48'h0000_766F_6964;
    localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

endpackage

/* rtl/st_if.sv */
// ----------------------------------------------------------------------------
// st_byte_if / st_token_if
// Valid/ready channels for source bytes and for token results.
// ----------------------------------------------------------------------------
interface st_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface st_token_if #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 24,
    parameter int LENGTH_BITS   = 16
);
    logic                     valid;
    logic                     ready;
    logic [5:0]               token_kind;
    logic [1:0]               error_code;
    logic [POSITION_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0]   token_length;
    logic [LINE_BITS-1:0]     line_number;
    logic [30:0]              number_value;
    logic                     last_result;

    modport source (output valid, output token_kind, output error_code,
                    output start_offset, output token_length, output line_number,
                    output number_value, output last_result, input ready);
    modport sink (input valid, input token_kind, input error_code,
                  input start_offset, input token_length, input line_number,
                  input number_value, input last_result, output ready);
endinterface

/* rtl/st_scan.sv */
// ----------------------------------------------------------------------------
// st_scan
// Front end: takes one byte per cycle while the queue has room, runs the
// lexer mode machine and queues zero, one or two finished results per byte.
// ----------------------------------------------------------------------------
module st_scan #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 24,
    parameter int LENGTH_BITS   = 16,
    parameter int RW            = 6 + 2 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 31
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    st_byte_if.sink         i_src,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output logic [2*RW:0]   o_push_data
);
    import st_pkg::*;

    logic [3:0]               r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LINE_BITS-1:0]     r_line,  n_line;
    logic [LENGTH_BITS-1:0]   r_len,   n_len;
    logic [NUM_BITS-1:0]      r_num,   n_num;
    logic [47:0]              r_kw,    n_kw;

    logic [7:0]               c;
    logic                     fire;
    logic                     rescan;
    logic                     a_v, b_v, p_v;
    logic [RW-1:0]            a_e, b_e, p_e;
    logic [5:0]               id_kind;
    logic [5:0]               op_kind;
    logic                     op_hit;
    logic [LENGTH_BITS-1:0]   len_inc;
    logic [LINE_BITS-1:0]     line_inc;
    logic [34:0]              num_mul;

    // Pack one result with the current line count.
    function automatic logic [RW-1:0] mk(input logic [5:0] k, input logic [1:0] e,
                                         input logic [POSITION_BITS-1:0] s,
                                         input logic [LENGTH_BITS-1:0] l,
                                         input logic [LINE_BITS-1:0] ln,
                                         input logic [NUM_BITS-1:0] v);
        return {k, e, s, l, ln, v};
    endfunction

    assign c     = i_src.source_byte;
    assign fire  = i_src.valid && i_src.ready;
    assign i_src.ready = i_push_ready;

    // Saturating counters and the decimal accumulator step.
    assign len_inc  = (&r_len)  ? r_len  : r_len + 1'b1;
    assign line_inc = (&r_line) ? r_line : r_line + 1'b1;
    assign num_mul  = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1) + {31'd0, c[3:0]};

    // Identifier or keyword.
    always_comb begin
        id_kind = K_IDENT;
        if (r_len == LENGTH_BITS'(3) && r_kw == KW_INT) begin
            id_kind = K_INT;
        end else if (r_len == LENGTH_BITS'(4) && r_kw == KW_VOID) begin
            id_kind = K_VOID;
        end else if (r_len == LENGTH_BITS'(6) && r_kw == KW_RETURN) begin
            id_kind = K_RETURN;
        end
    end

    // Token held by a pending mode, emitted when the next byte ends it.
    always_comb begin
        p_v = 1'b1;
        p_e = '0;
        case (r_mode)
            M_IDENT:   p_e = mk(id_kind, E_NONE, r_start, r_len, r_line, '0);
            M_NUMBER:  p_e = mk(K_NUMBER, E_NONE, r_start, r_len, r_line, r_num);
            M_SLASH:   p_e = mk(K_SLASH, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            M_MINUS:   p_e = mk(K_MINUS, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            M_BANG:    p_e = mk(K_BANG, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            M_EQUAL:   p_e = mk(K_EQ, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            M_LESS:    p_e = mk(K_LT, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            M_GREATER: p_e = mk(K_GT, E_NONE, r_start, LENGTH_BITS'(1), r_line, '0);
            default:   p_v = 1'b0;
        endcase
    end

    // Second character of a two-character operator.
    always_comb begin
        op_hit  = 1'b1;
        op_kind = K_DEC;
        if (r_mode == M_MINUS && c == "-") begin
            op_kind = K_DEC;
        end else if (r_mode == M_BANG && c == "=") begin
            op_kind = K_BANG_EQ;
        end else if (r_mode == M_EQUAL && c == "=") begin
            op_kind = K_EQ_EQ;
        end else if (r_mode == M_LESS && c == "=") begin
            op_kind = K_LE;
        end else if (r_mode == M_LESS && c == "<") begin
            op_kind = K_SHL;
        end else if (r_mode == M_GREATER && c == "=") begin
            op_kind = K_GE;
        end else if (r_mode == M_GREATER && c == ">") begin
            op_kind = K_SHR;
        end else begin
            op_hit = 1'b0;
        end
    end

    // Mode machine: the first result comes from the current mode, the second
    // from scanning the byte afresh or from the end of source.
    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_start = r_start; n_line = r_line;
        n_len = r_len; n_num = r_num; n_kw = r_kw;
        a_v = 1'b0; a_e = '0; b_v = 1'b0; b_e = '0; rescan = 1'b0;
        if (fire) begin
            if (c == 8'd0) begin
                if (r_mode == M_STRING) begin
                    a_v = 1'b1;
                    a_e = mk(K_ERROR, E_STRING, r_start, r_len, r_line, '0);
                end else if (r_mode != M_ERROR) begin
                    a_v = p_v;
                    a_e = p_e;
                    b_v = 1'b1;
                    b_e = mk(K_EOF, E_NONE, r_pos, '0, r_line, '0);
                end
                n_mode = M_IDLE; n_pos = '0; n_start = '0; n_line = LINE_BITS'(1);
                n_len = '0; n_num = '0; n_kw = '0;
            end else begin
                n_pos = r_pos + 1'b1;
                unique case (r_mode)
                    M_ERROR: begin
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            n_len = len_inc;
                            n_kw  = {r_kw[39:0], c};
                        end else begin
                            a_v = 1'b1; a_e = p_e; rescan = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(c)) begin
                            n_len = len_inc;
                            n_num = (num_mul > {4'd0, NUM_MAX}) ? NUM_MAX
                                                                : num_mul[NUM_BITS-1:0];
                        end else if (is_alpha(c)) begin
                            n_len  = len_inc;
                            a_v    = 1'b1;
                            a_e    = mk(K_ERROR, E_DIGIT, r_start, len_inc, r_line, '0);
                            n_mode = M_ERROR;
                        end else begin
                            a_v = 1'b1; a_e = p_e; rescan = 1'b1;
                        end
                    end
                    M_STRING: begin
                        n_len = len_inc;
                        if (c == "\"") begin
                            a_v    = 1'b1;
                            a_e    = mk(K_STRING, E_NONE, r_start, len_inc, r_line, '0);
                            n_mode = M_IDLE;
                        end else if (c == 8'h0A) begin
                            n_line = line_inc;
                        end
                    end
                    M_SLASH: begin
                        if (c == "/") begin
                            n_mode = M_COMMENT;
                        end else begin
                            a_v = 1'b1; a_e = p_e; rescan = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == 8'h0A) begin
                            rescan = 1'b1;
                        end
                    end
                    M_MINUS, M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                        a_v = 1'b1;
                        if (op_hit) begin
                            a_e    = mk(op_kind, E_NONE, r_start, LENGTH_BITS'(2), r_line, '0);
                            n_mode = M_IDLE;
                        end else begin
                            a_e = p_e; rescan = 1'b1;
                        end
                    end
                    default: rescan = 1'b1;
                endcase

                // Byte scanned between tokens.
                if (rescan) begin
                    n_mode  = M_IDLE;
                    n_start = r_pos;
                    n_len   = LENGTH_BITS'(1);
                    b_v     = 1'b1;
                    b_e     = mk(K_ERROR, E_CHAR, r_pos, LENGTH_BITS'(1), r_line, '0);
                    if (c == " " || c == 8'h09 || c == 8'h0D) begin
                        b_v = 1'b0;
                    end else if (c == 8'h0A) begin
                        b_v = 1'b0; n_line = line_inc;
                    end else if (is_alpha(c)) begin
                        b_v = 1'b0; n_mode = M_IDENT; n_kw = {40'd0, c};
                    end else if (is_digit(c)) begin
                        b_v = 1'b0; n_mode = M_NUMBER; n_num = {27'd0, c[3:0]};
                    end else begin
                        unique case (c)
                            "(": b_e[RW-1 -: 6] = K_LPAREN;
                            ")": b_e[RW-1 -: 6] = K_RPAREN;
                            "{": b_e[RW-1 -: 6] = K_LBRACE;
                            "}": b_e[RW-1 -: 6] = K_RBRACE;
                            ";": b_e[RW-1 -: 6] = K_SEMI;
                            ",": b_e[RW-1 -: 6] = K_COMMA;
                            ".": b_e[RW-1 -: 6] = K_DOT;
                            "+": b_e[RW-1 -: 6] = K_PLUS;
                            "*": b_e[RW-1 -: 6] = K_STAR;
                            "~": b_e[RW-1 -: 6] = K_TILDE;
                            "%": b_e[RW-1 -: 6] = K_MOD;
                            "&": b_e[RW-1 -: 6] = K_AND;
                            "|": b_e[RW-1 -: 6] = K_OR;
                            "^": b_e[RW-1 -: 6] = K_XOR;
                            "/": begin b_v = 1'b0; n_mode = M_SLASH; end
                            "-": begin b_v = 1'b0; n_mode = M_MINUS; end
                            "!": begin b_v = 1'b0; n_mode = M_BANG; end
                            "=": begin b_v = 1'b0; n_mode = M_EQUAL; end
                            "<": begin b_v = 1'b0; n_mode = M_LESS; end
                            ">": begin b_v = 1'b0; n_mode = M_GREATER; end
                            "\"": begin b_v = 1'b0; n_mode = M_STRING; end
                            default: n_mode = M_ERROR;
                        endcase
                        // Known single characters carry no error code.
                        if (n_mode != M_ERROR) begin
                            b_e[RW-7 -: 2] = E_NONE;
                        end
                    end
                end
            end
        end
    end

    // Queue entry: a two-result flag over the second and first results.
    assign o_push_valid = fire && (a_v || b_v);
    assign o_push_data  = {a_v && b_v, b_e, (a_v ? a_e : b_e)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_start <= '0; r_line <= LINE_BITS'(1);
            r_len <= '0; r_num <= '0; r_kw <= '0;
        end else begin
            r_mode <= n_mode; r_pos <= n_pos; r_start <= n_start; r_line <= n_line;
            r_len <= n_len; r_num <= n_num; r_kw <= n_kw;
        end
    end

endmodule

/* rtl/st_queue.sv */
// ----------------------------------------------------------------------------
// st_queue
// Small FIFO that decouples the scanner from the output stage.
// ----------------------------------------------------------------------------
module st_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  logic [DW-1:0] i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output logic [DW-1:0] o_pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0]  r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_count;
    logic           push, pop;

    assign o_push_ready = r_count != (AW+1)'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

/* rtl/st_emit.sv */
// ----------------------------------------------------------------------------
// st_emit
// Back end: takes queue entries and presents their one or two results in
// order on the token channel from an output register.
// ----------------------------------------------------------------------------
module st_emit #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 24,
    parameter int LENGTH_BITS   = 16,
    parameter int RW            = 6 + 2 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  logic [2*RW:0] i_pop_data,
    st_token_if.source    o_tok
);
    logic [2*RW:0] r_ent;
    logic          r_busy, r_phase;
    logic [RW-1:0] slot;
    logic          last;

    assign slot = r_phase ? r_ent[2*RW-1:RW] : r_ent[RW-1:0];
    assign last = r_phase || !r_ent[2*RW];
    assign o_pop_ready = !r_busy || (o_tok.ready && last);

    // Field unpacking of the current result.
    assign o_tok.valid        = r_busy;
    assign o_tok.number_value = slot[30:0];
    assign o_tok.line_number  = slot[31 +: LINE_BITS];
    assign o_tok.token_length = slot[31+LINE_BITS +: LENGTH_BITS];
    assign o_tok.start_offset = slot[31+LINE_BITS+LENGTH_BITS +: POSITION_BITS];
    assign o_tok.error_code   = slot[RW-7 -: 2];
    assign o_tok.token_kind   = slot[RW-1 -: 6];
    assign o_tok.last_result  = last;

    // Entry register and result phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_phase <= 1'b0;
        end else if (i_pop_valid && o_pop_ready) begin
            r_busy <= 1'b1; r_phase <= 1'b0;
        end else if (r_busy && o_tok.ready) begin
            r_busy  <= !last;
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid && o_pop_ready) begin
            r_ent <= i_pop_data;
        end
    end

endmodule

/* rtl/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, tokens with position, line and value out.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   i_src    in   source_byte (zero ends the source)
//   o_tok    out  token_kind, error_code, start_offset, token_length,
//                 line_number, number_value, last_result
//
// One byte is accepted per cycle while the four-entry queue has room; the
// scanner's mode machine settles each byte in that cycle. A byte that yields
// two results presents them one at a time on the output. Results pass
// through the queue memory and then the emit stage's entry register.
// Reset clears all control state; no memory needs a clearing pass.
module source_tokenizer #(
    parameter int POSITION_BITS = st_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = st_pkg::LINE_BITS_DEF,
    parameter int LENGTH_BITS   = st_pkg::LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    st_byte_if.sink    i_src,
    st_token_if.source o_tok
);
    import st_pkg::*;

    localparam int RW = 6 + 2 + POSITION_BITS + LENGTH_BITS + LINE_BITS + NUM_BITS;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [2*RW:0] push_data, pop_data;

    st_scan #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS),
              .LENGTH_BITS(LENGTH_BITS), .RW(RW)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(i_src),
        .o_push_valid(push_valid), .i_push_ready(push_ready), .o_push_data(push_data)
    );

    st_queue #(.DW(2*RW+1), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(push_valid), .o_push_ready(push_ready), .i_push_data(push_data),
        .o_pop_valid(pop_valid), .i_pop_ready(pop_ready), .o_pop_data(pop_data)
    );

    st_emit #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS),
              .LENGTH_BITS(LENGTH_BITS), .RW(RW)) u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pop_valid(pop_valid), .o_pop_ready(pop_ready), .i_pop_data(pop_data),
        .o_tok(o_tok)
    );

    // An error code appears exactly on error tokens.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid |-> ((o_tok.error_code != E_NONE) == (o_tok.token_kind == K_ERROR)))
        else $error("error code does not match token kind");

    // Only numbers carry a value.
    a_num_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.number_value != '0) |-> (o_tok.token_kind == K_NUMBER))
        else $error("value on a non-number token");

    // The scanner only writes the queue for an accepted byte.
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> (i_src.valid && i_src.ready && push_ready))
        else $error("queue write without an accepted byte");

endmodule
